// File: sv/brl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COLOR_BITS     = 16;

  // per-item commands from the top level to the line walker
  typedef struct packed {
    logic load;
    logic step;
  } walk_ctl_t;

endpackage

`default_nettype wire

// File: sv/brl_setup.sv
`timescale 1ns / 1ps
`default_nettype none

module brl_setup #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  ld_x_neg,
  output logic                  ld_y_neg,
  output logic                  ld_x_major,
  output logic [COORD_BITS+2:0] ld_decision,
  output logic [COORD_BITS+2:0] ld_inc_step,
  output logic [COORD_BITS:0]   ld_twice_minor,
  output logic [COORD_BITS:0]   ld_remaining
);

  logic [COORD_BITS-1:0] abs_dx;
  logic [COORD_BITS-1:0] abs_dy;
  logic [COORD_BITS-1:0] major;
  logic [COORD_BITS-1:0] minor;

  always_comb begin
    ld_x_neg   = x_end < x_start;
    ld_y_neg   = y_end < y_start;
    abs_dx     = ld_x_neg ? (x_start - x_end) : (x_end - x_start);
    abs_dy     = ld_y_neg ? (y_start - y_end) : (y_end - y_start);
    // ties go to the y axis
    ld_x_major = abs_dx > abs_dy;
    major      = ld_x_major ? abs_dx : abs_dy;
    minor      = ld_x_major ? abs_dy : abs_dx;

    ld_twice_minor = {minor, 1'b0};
    ld_decision    = {2'b00, minor, 1'b0} - {3'b000, major};
    // added to the error term when the minor axis advances
    ld_inc_step    = {2'b00, minor, 1'b0} - {2'b00, major, 1'b0};
    ld_remaining   = {1'b0, major} + {{COORD_BITS{1'b0}}, 1'b1};
  end

endmodule

`default_nettype wire

// File: sv/brl_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module brl_walker #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  brl_pkg::walk_ctl_t            ctl,
  input  logic [COORD_BITS-1:0]         ld_x,
  input  logic [COORD_BITS-1:0]         ld_y,
  input  logic                          ld_x_neg,
  input  logic                          ld_y_neg,
  input  logic                          ld_x_major,
  input  logic [COORD_BITS+2:0]         ld_decision,
  input  logic [COORD_BITS+2:0]         ld_inc_step,
  input  logic [COORD_BITS:0]           ld_twice_minor,
  input  logic [COORD_BITS:0]           ld_remaining,
  input  logic [brl_pkg::COLOR_BITS-1:0] ld_color,
  output logic                          busy,
  output logic [COORD_BITS-1:0]         cur_x,
  output logic [COORD_BITS-1:0]         cur_y,
  output logic [brl_pkg::COLOR_BITS-1:0] held_color,
  output logic                          last
);

  logic [COORD_BITS:0]   remaining;
  logic [COORD_BITS+2:0] decision;
  logic [COORD_BITS+2:0] inc_step;
  logic [COORD_BITS:0]   twice_minor;
  logic                  x_step_neg;
  logic                  y_step_neg;
  logic                  x_is_major;

  logic                  minor_adv;
  logic                  x_adv;
  logic                  y_adv;
  logic [COORD_BITS+2:0] decision_next;
  logic [COORD_BITS-1:0] cur_x_next;
  logic [COORD_BITS-1:0] cur_y_next;

  always_comb begin
    minor_adv     = !decision[COORD_BITS+2];
    x_adv         = x_is_major || minor_adv;
    y_adv         = !x_is_major || minor_adv;
    decision_next = decision + (minor_adv ? inc_step : {2'b00, twice_minor});
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    if (x_adv) begin
      cur_x_next = x_step_neg ? (cur_x - 1'b1) : (cur_x + 1'b1);
    end
    if (y_adv) begin
      cur_y_next = y_step_neg ? (cur_y - 1'b1) : (cur_y + 1'b1);
    end
    last = remaining == {{COORD_BITS{1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (ctl.load) begin
      busy      <= 1'b1;
      remaining <= ld_remaining;
    end else if (ctl.step) begin
      busy      <= !last;
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur_x       <= ld_x;
      cur_y       <= ld_y;
      decision    <= ld_decision;
      inc_step    <= ld_inc_step;
      twice_minor <= ld_twice_minor;
      x_step_neg  <= ld_x_neg;
      y_step_neg  <= ld_y_neg;
      x_is_major  <= ld_x_major;
      held_color  <= ld_color;
    end else if (ctl.step) begin
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      decision <= decision_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/bresenham_line_raster_top.sv
`timescale 1ns / 1ps
`default_nettype none

// bresenham line rasterizer
// s_axis carries commands: tuser = 1 starts a line from the two end points and
// color in tdata, tuser = 0 is a tick that asks for the next pixel. a start gives
// no pixel; each tick while a line is active gives one pixel on m_axis, with
// tlast set on the line's end point. a tick with no active line gives nothing,
// and a start during a line drops the rest of that line.
// a line from the end points gives max(|dx|, |dy|) + 1 pixels, both ends included.
// a tick's pixel passes the input register, then the output register, to m_axis.
// throughput: one command per cycle unless m_axis stalls; each step is one add on
// the error term and an increment per axis between the input and output registers.
// the output register holds its pixel while m_axis_tready is low; one more
// command is taken into the input register, after which s_axis_tready drops
// until the pixel is taken.
// reset (rst, synchronous) empties both registers and ends any active line.

module bresenham_line_raster_top #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  localparam int InW  = ((4 * COORD_BITS + brl_pkg::COLOR_BITS + 7) / 8) * 8,
  localparam int OutW = ((2 * COORD_BITS + brl_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // x_start, y_start, x_end, y_end, line_color, zero pad
  input  logic [InW-1:0]  s_axis_tdata,
  // action
  input  logic            s_axis_tuser,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [OutW-1:0] m_axis_tdata,
  // last_pixel
  output logic            m_axis_tlast
);

  localparam int C    = COORD_BITS;
  localparam int CLR  = brl_pkg::COLOR_BITS;
  localparam int UseW = 4 * C + CLR;
  localparam int PixW = 2 * C + CLR;

  logic            in_valid;
  logic            in_action;
  logic [UseW-1:0] in_data;
  logic            advance;

  brl_pkg::walk_ctl_t ctl;

  logic                ld_x_neg;
  logic                ld_y_neg;
  logic                ld_x_major;
  logic [C+2:0]        ld_decision;
  logic [C+2:0]        ld_inc_step;
  logic [C:0]          ld_twice_minor;
  logic [C:0]          ld_remaining;
  logic                busy;
  logic [C-1:0]        cur_x;
  logic [C-1:0]        cur_y;
  logic [CLR-1:0]      held_color;
  logic                last;
  logic [PixW-1:0]     pix_data;

  always_comb begin
    advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
    s_axis_tready = !in_valid || advance;
    ctl.load      = advance && in_action;
    ctl.step      = advance && !in_action && busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser;
      in_data   <= s_axis_tdata[UseW-1:0];
    end
  end

  brl_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .x_start        (in_data[C-1:0]),
    .y_start        (in_data[2*C-1:C]),
    .x_end          (in_data[3*C-1:2*C]),
    .y_end          (in_data[4*C-1:3*C]),
    .ld_x_neg       (ld_x_neg),
    .ld_y_neg       (ld_y_neg),
    .ld_x_major     (ld_x_major),
    .ld_decision    (ld_decision),
    .ld_inc_step    (ld_inc_step),
    .ld_twice_minor (ld_twice_minor),
    .ld_remaining   (ld_remaining)
  );

  brl_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .ld_x           (in_data[C-1:0]),
    .ld_y           (in_data[2*C-1:C]),
    .ld_x_neg       (ld_x_neg),
    .ld_y_neg       (ld_y_neg),
    .ld_x_major     (ld_x_major),
    .ld_decision    (ld_decision),
    .ld_inc_step    (ld_inc_step),
    .ld_twice_minor (ld_twice_minor),
    .ld_remaining   (ld_remaining),
    .ld_color       (in_data[UseW-1:4*C]),
    .busy           (busy),
    .cur_x          (cur_x),
    .cur_y          (cur_y),
    .held_color     (held_color),
    .last           (last)
  );

  // output register: refilled whenever it is empty or its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= ctl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      pix_data     <= {held_color, cur_y, cur_x};
      m_axis_tlast <= last;
    end
  end

  always_comb begin
    m_axis_tdata = {{(OutW - PixW){1'b0}}, pix_data};
  end

endmodule

`default_nettype wire

// File: sv/brl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module brl_checker #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  localparam int OutW = ((2 * COORD_BITS + brl_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input logic            clk,
  input logic            rst,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            s_axis_tuser,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic            m_axis_tlast
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled pixel holds
  assert property (@(posedge clk) disable iff (rst)
    out_stall |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled pixel changed");

  // both registers come out of reset empty
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("registers not empty after reset");

  // a pixel only comes from a command that passed through the input register
  assert property (@(posedge clk) disable iff (rst)
    (!in_xfer && !out_stall) ##1 !out_stall |=> !m_axis_tvalid)
    else $error("pixel without a command");

  // the input side is never blocked while the output register is free
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with free output");

  // a start command by itself never yields a pixel
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tuser && !out_stall) ##1 (!in_xfer && !out_stall) ##1 !out_stall
      |=> !m_axis_tvalid)
    else $error("pixel from a start command");

endmodule

bind bresenham_line_raster_top brl_checker #(
  .COORD_BITS(COORD_BITS)
) u_brl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// expected-pixel generator and checker for the line walker
class line_walk_model;
  typedef struct {
    logic [9:0]  px;
    logic [9:0]  py;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  pixel_t      expected_pixels[$];
  int          errors;
  bit          busy;
  logic [9:0]  cur_x;
  logic [9:0]  cur_y;
  int          decision;
  int          remaining;
  int          twice_major;
  int          twice_minor;
  bit          x_neg;
  bit          y_neg;
  bit          x_major;
  logic [15:0] color;

  function new();
    errors = 0;
    busy = 0;
    cur_x = '0;
    cur_y = '0;
    decision = 0;
    remaining = 0;
    twice_major = 0;
    twice_minor = 0;
    x_neg = 0;
    y_neg = 0;
    x_major = 0;
    color = '0;
  endfunction

  // call once per accepted command transfer
  function void note_command(bit start, logic [55:0] d);
    int xs, ys, xe, ye, dx, dy, major, minor;
    pixel_t p;
    if (start) begin
      xs = int'(d[9:0]);
      ys = int'(d[19:10]);
      xe = int'(d[29:20]);
      ye = int'(d[39:30]);
      dx = xe - xs;
      dy = ye - ys;
      x_neg = dx < 0;
      y_neg = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      x_major = dx > dy;
      major = x_major ? dx : dy;
      minor = x_major ? dy : dx;
      twice_major = 2 * major;
      twice_minor = 2 * minor;
      decision = 2 * minor - major;
      remaining = major + 1;
      cur_x = d[9:0];
      cur_y = d[19:10];
      color = d[55:40];
      busy = 1;
    end else if (busy) begin
      p.px = cur_x;
      p.py = cur_y;
      p.color = color;
      p.last = (remaining == 1);
      expected_pixels.push_back(p);
      if (decision >= 0) begin
        decision -= twice_major;
        if (x_major) cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
        else cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      decision += twice_minor;
      if (x_major) cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      else cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      if (remaining <= 1) begin
        remaining = 0;
        busy = 0;
      end else begin
        remaining--;
      end
    end
  endfunction

  function void check_pixel(logic [39:0] d, logic last);
    pixel_t p;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
               d[9:0], d[19:10], d[35:20], last);
      errors++;
      return;
    end
    p = expected_pixels.pop_front();
    if (d[9:0] !== p.px) begin
      $display("%0t: pixel_x expected %0d actual %0d", $time, p.px, d[9:0]);
      errors++;
    end
    if (d[19:10] !== p.py) begin
      $display("%0t: pixel_y expected %0d actual %0d", $time, p.py, d[19:10]);
      errors++;
    end
    if (d[35:20] !== p.color) begin
      $display("%0t: pixel_color expected %h actual %h", $time, p.color, d[35:20]);
      errors++;
    end
    if (last !== p.last) begin
      $display("%0t: last_pixel expected %b actual %b", $time, p.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_pixels.size();
  endfunction
endclass

module testbench;
  localparam int IN_W  = 56;
  localparam int OUT_W = 40;
  localparam int CMD_TARGET = 1250;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  line_walk_model walker = new();
  int burst_left = 0;
  int sent_cmds = 0;
  bit held_off = 0;

  always #6 clk = ~clk;

  bresenham_line_raster_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      walker.check_pixel(m_axis_tdata, m_axis_tlast);
  end

  function automatic logic [IN_W-1:0] line_cmd(int xs, int ys, int xe, int ye, int c);
    logic [9:0] a, b, e, f;
    logic [15:0] col;
    a = 10'(xs);
    b = 10'(ys);
    e = 10'(xe);
    f = 10'(ye);
    col = 16'(c);
    return {col, f, e, b, a};
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // sender side: bursts of transfers separated by random gaps
  task automatic send_cmd(input bit start, input logic [IN_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= start;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    walker.note_command(start, d);
    sent_cmds++;
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_cmd(1'b0, IN_W'({$urandom, $urandom}));
  endtask

  task automatic draw(input int xs, input int ys, input int xe, input int ye,
                      input int c, input int n);
    send_cmd(1'b1, line_cmd(xs, ys, xe, ye, c));
    send_ticks(n);
  endtask

  // receiver side: phases of different stall patterns, plus one long hold-off
  initial begin
    int mode, len;
    logic [7:0] pat;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(10, 80);
      pat = 8'($urandom);
      for (int i = 0; i < len; i++) begin
        @(posedge clk);
        if (!held_off && sent_cmds >= 500) begin
          held_off = 1;
          m_axis_tready <= 1'b0;
          repeat (200) @(posedge clk);
        end
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= pat[i % 8];
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int xs, ys, xe, ye, c, len, n, r, waited;
    bit long_done;
    long_done = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, single-point line, restart mid-line, tie and steep lines
    send_ticks(1);
    draw(5, 5, 5, 5, 16'h0000, 2);
    draw(0, 0, 4, 2, 16'hffff, 2);
    draw(1023, 1023, 1019, 1021, 16'ha5a5, 6);
    draw(1023, 0, 1020, 3, 16'h5a5a, 4);
    draw(0, 1023, 1, 1020, 16'h8001, 4);

    while (sent_cmds < CMD_TARGET) begin
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 16'hffff : 0)
                                       : $urandom_range(0, 65535);
      if (!long_done && sent_cmds > 150) begin
        // full-width line, longest count of pixels
        long_done = 1;
        if ($urandom_range(0, 1) != 0) draw(0, $urandom_range(0, 1023), 1023,
                                            $urandom_range(0, 1023), c, 1025);
        else draw(1023, $urandom_range(0, 1023), 0, $urandom_range(0, 1023), c, 1025);
      end else if (r < 6) begin
        send_ticks($urandom_range(1, 4));
      end else if (r < 12) begin
        // wide-range line, usually cut short by the next start
        draw($urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 1023), c, $urandom_range(0, 60));
      end else begin
        xs = $urandom_range(0, 1023);
        ys = $urandom_range(0, 1023);
        xe = clamp_coord(xs + $urandom_range(0, 48) - 24);
        ye = ($urandom_range(0, 7) == 0) ? clamp_coord(ys + (xe - xs))
                                          : clamp_coord(ys + $urandom_range(0, 48) - 24);
        len = (xe > xs ? xe - xs : xs - xe);
        if ((ye > ys ? ye - ys : ys - ye) > len) len = (ye > ys ? ye - ys : ys - ye);
        if ($urandom_range(0, 4) == 0) n = $urandom_range(0, len);
        else n = len + 1 + $urandom_range(0, 2);
        draw(xs, ys, xe, ye, c, n);
      end
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (walker.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (walker.pending() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time, walker.pending());
      walker.errors++;
    end
    if (walker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/brl_pkg.sv
sv/brl_setup.sv
sv/brl_walker.sv
sv/bresenham_line_raster_top.sv
sv/brl_checker.sv
tb/sv/testbench.sv
